// ----- hdl/ulst_pkg.sv -----
// shared constants, codes and types for the unique list engine
package ulst_pkg;

    localparam int DEPTH    = 16;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    localparam int KIND_W   = 4;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 5;
    localparam int STAT_W   = 3;
    localparam int FIDX_W   = 4;
    localparam int SPREAD_W = 32;

    // position arithmetic width, wide enough for both the field and the count
    localparam int EP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int IN_USER_W  = KIND_W;
    localparam int IN_DATA_W  = ((VAL_W + POS_W + 7) / 8) * 8;
    localparam int OUT_BITS   = STAT_W + FIDX_W + CNT_W + SPREAD_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;
    localparam int IN_PAD_W   = IN_DATA_W - VAL_W - POS_W;

    // min/max reduction tree
    localparam int TREE_LVLS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TREE_N    = 1 << TREE_LVLS;
    localparam int LVL_W     = $clog2(TREE_LVLS + 1);

    // command queue between front and back
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR     = 4'd0,
        KIND_SEARCH    = 4'd1,
        KIND_INS_END   = 4'd2,
        KIND_INS_START = 4'd3,
        KIND_INS_POS   = 4'd4,
        KIND_RM_END    = 4'd5,
        KIND_RM_START  = 4'd6,
        KIND_RM_POS    = 4'd7,
        KIND_RM_VALUE  = 4'd8
    } kind_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_SEARCH,
        OP_INS_END,
        OP_INS_START,
        OP_INS_POS,
        OP_RM_END,
        OP_RM_START,
        OP_RM_POS,
        OP_RM_VALUE
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_BADPOS  = 3'd3,
        ST_DUP     = 3'd4,
        ST_MISSING = 3'd5
    } status_t;

    typedef struct packed {
        op_t                     op;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } cmd_t;

endpackage

// ----- hdl/ulst_front.sv -----
// front end: takes beats, decodes the kind and queues commands for the back end
module ulst_front
    import ulst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_USER_W-1:0] s_axis_tuser,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    output logic                 q_valid,
    input  logic                 q_ready,
    output cmd_t                 q_cmd
);

    cmd_t               q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    cmd_t               in_cmd;
    logic               push;
    logic               pop;

    always_comb
    begin
        in_cmd.value    = s_axis_tdata[VAL_W-1:0];
        in_cmd.position = s_axis_tdata[VAL_W+POS_W-1:VAL_W];
        case (s_axis_tuser)
            KIND_CLEAR:     in_cmd.op = OP_CLEAR;
            KIND_SEARCH:    in_cmd.op = OP_SEARCH;
            KIND_INS_END:   in_cmd.op = OP_INS_END;
            KIND_INS_START: in_cmd.op = OP_INS_START;
            KIND_INS_POS:   in_cmd.op = OP_INS_POS;
            KIND_RM_END:    in_cmd.op = OP_RM_END;
            KIND_RM_START:  in_cmd.op = OP_RM_START;
            KIND_RM_POS:    in_cmd.op = OP_RM_POS;
            KIND_RM_VALUE:  in_cmd.op = OP_RM_VALUE;
            default:        in_cmd.op = OP_NOP;
        endcase
    end

    assign s_axis_tready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign q_valid       = (count_reg != '0);
    assign q_cmd         = q_mem_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- hdl/ulst_back.sv -----
// back end: runs list commands, reduces min/max for the spread, holds the result beat
module ulst_back
    import ulst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  cmd_t                  q_cmd,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MATCH  = 7'b0000010,
        S_EXEC   = 7'b0000100,
        S_LOAD   = 7'b0001000,
        S_REDUCE = 7'b0010000,
        S_DIFF   = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    logic signed [VAL_W-1:0] entries_reg [DEPTH];
    logic signed [VAL_W-1:0] entries_next [DEPTH];
    logic [CNT_W-1:0]        used_reg, used_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [DEPTH-1:0]        match_reg, match_next;
    logic signed [VAL_W-1:0] lo_reg [TREE_N];
    logic signed [VAL_W-1:0] lo_next [TREE_N];
    logic signed [VAL_W-1:0] hi_reg [TREE_N];
    logic signed [VAL_W-1:0] hi_next [TREE_N];
    logic [LVL_W-1:0]        lvl_reg, lvl_next;
    status_t                 res_status_reg, res_status_next;
    logic [FIDX_W-1:0]       res_fidx_reg, res_fidx_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;

    logic                    pop;
    logic                    hit;
    logic [IDX_W-1:0]        hit_idx;
    logic                    is_ins;
    logic                    is_rm;
    logic [EP_W-1:0]         eff_pos;
    logic [EP_W-1:0]         used_ext;
    status_t                 exec_status;
    logic [SPREAD_W-1:0]     spread;

    assign q_ready       = (state_reg == S_IDLE) || ((state_reg == S_OUT) && m_axis_tready);
    assign pop           = q_valid && q_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign used_ext      = EP_W'(used_reg);

    // execute-stage decode, uses the registered match vector
    always_comb
    begin
        hit     = |match_reg;
        hit_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end

        is_ins = (cmd_reg.op == OP_INS_END) || (cmd_reg.op == OP_INS_START)
              || (cmd_reg.op == OP_INS_POS);
        is_rm  = (cmd_reg.op == OP_RM_END) || (cmd_reg.op == OP_RM_START)
              || (cmd_reg.op == OP_RM_POS) || (cmd_reg.op == OP_RM_VALUE);

        case (cmd_reg.op)
            OP_INS_END:  eff_pos = used_ext;
            OP_INS_POS:  eff_pos = EP_W'(cmd_reg.position);
            OP_RM_END:   eff_pos = used_ext - EP_W'(1);
            OP_RM_POS:   eff_pos = EP_W'(cmd_reg.position);
            OP_RM_VALUE: eff_pos = EP_W'(hit_idx);
            default:     eff_pos = '0;
        endcase

        exec_status = ST_OK;
        if (is_ins)
        begin
            if (used_reg >= CNT_W'(DEPTH))
            begin
                exec_status = ST_FULL;
            end
            else if (eff_pos > used_ext)
            begin
                exec_status = ST_BADPOS;
            end
            else if (hit)
            begin
                exec_status = ST_DUP;
            end
        end
        else if (is_rm)
        begin
            if (used_reg == '0)
            begin
                exec_status = ST_EMPTY;
            end
            else if ((cmd_reg.op == OP_RM_VALUE) && !hit)
            begin
                exec_status = ST_MISSING;
            end
            else if (eff_pos >= used_ext)
            begin
                exec_status = ST_BADPOS;
            end
        end
        else if (cmd_reg.op == OP_SEARCH)
        begin
            if (!hit)
            begin
                exec_status = ST_MISSING;
            end
        end
    end

    always_comb
    begin
        spread = (used_reg == '0) ? '0 : SPREAD_W'(hi_reg[0] - lo_reg[0]);
    end

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        cmd_next        = cmd_reg;
        match_next      = match_reg;
        lvl_next        = lvl_reg;
        res_status_next = res_status_reg;
        res_fidx_next   = res_fidx_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            entries_next[i] = entries_reg[i];
        end
        for (int i = 0; i < TREE_N; i++)
        begin
            lo_next[i] = lo_reg[i];
            hi_next[i] = hi_reg[i];
        end

        if (pop)
        begin
            cmd_next = q_cmd;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    match_next[i] = (entries_reg[i] == cmd_reg.value)
                                 && (CNT_W'(i) < used_reg);
                end
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                res_status_next = exec_status;
                res_fidx_next   = ((cmd_reg.op == OP_SEARCH) && hit) ? FIDX_W'(hit_idx) : '0;
                if (cmd_reg.op == OP_CLEAR)
                begin
                    used_next = '0;
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        entries_next[i] = '0;
                    end
                end
                else if (is_ins && (exec_status == ST_OK))
                begin
                    // open a slot at the position by shifting the tail up
                    for (int i = 1; i < DEPTH; i++)
                    begin
                        if (EP_W'(i) > eff_pos)
                        begin
                            entries_next[i] = entries_reg[i-1];
                        end
                    end
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (EP_W'(i) == eff_pos)
                        begin
                            entries_next[i] = cmd_reg.value;
                        end
                    end
                    used_next = used_reg + 1'b1;
                end
                else if (is_rm && (exec_status == ST_OK))
                begin
                    // slots past the count hold zero, so the top slot refills with zero
                    for (int i = 0; i < DEPTH - 1; i++)
                    begin
                        if (EP_W'(i) >= eff_pos)
                        begin
                            entries_next[i] = entries_reg[i+1];
                        end
                    end
                    entries_next[DEPTH-1] = '0;
                    used_next = used_reg - 1'b1;
                end
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // unused leaves copy slot zero so they never win
                for (int i = 0; i < TREE_N; i++)
                begin
                    if ((i < DEPTH) && (CNT_W'(i) < used_reg))
                    begin
                        lo_next[i] = entries_reg[(i < DEPTH) ? i : 0];
                        hi_next[i] = entries_reg[(i < DEPTH) ? i : 0];
                    end
                    else
                    begin
                        lo_next[i] = entries_reg[0];
                        hi_next[i] = entries_reg[0];
                    end
                end
                lvl_next   = '0;
                state_next = S_REDUCE;
            end
            S_REDUCE:
            begin
                for (int i = 0; i < TREE_N / 2; i++)
                begin
                    lo_next[i] = (lo_reg[2*i+1] < lo_reg[2*i]) ? lo_reg[2*i+1] : lo_reg[2*i];
                    hi_next[i] = (hi_reg[2*i+1] > hi_reg[2*i]) ? hi_reg[2*i+1] : hi_reg[2*i];
                end
                lvl_next = lvl_reg + 1'b1;
                if (lvl_reg == LVL_W'(TREE_LVLS - 1))
                begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                out_data_next  = {{OUT_PAD_W{1'b0}}, spread, used_reg, res_fidx_reg,
                                  res_status_reg};
                out_valid_next = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = pop ? S_MATCH : S_IDLE;
                end
            end
            default:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DEPTH; i++)
            begin
                entries_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < DEPTH; i++)
            begin
                entries_reg[i] <= entries_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        match_reg      <= match_next;
        lvl_reg        <= lvl_next;
        res_status_reg <= res_status_next;
        res_fidx_reg   <= res_fidx_next;
        out_data_reg   <= out_data_next;
        for (int i = 0; i < TREE_N; i++)
        begin
            lo_reg[i] <= lo_next[i];
            hi_reg[i] <= hi_next[i];
        end
    end

endmodule

// ----- hdl/unique_array_list_engine_core.sv -----
// top level of the unique list engine: command front end, queue and execution back end
//
//  channel  | dir | tdata (low bit up)                              | tuser
//  s_axis   | in  | value[31:0], position[36:32], zero pad to 40    | kind[3:0]
//  m_axis   | out | status[2:0], found_index[6:3], entry_count[11:7],| -
//           |     | spread[43:12], zero pad to 48                   |
//
// an item runs through the back end in order (match, execute, tree load, one reduce step per
// min/max tree level over 16 entries, difference) and then waits in the output register
// until taken; the next queued command starts in the cycle the result beat goes out.
// a two-entry command queue accepts beats while the back end works or stalls, until it is full.
// reset (rst_n low, asynchronous) empties the queue, zeroes the list and the count.
module unique_array_list_engine_core
    import ulst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_USER_W-1:0]  s_axis_tuser,   // kind
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // value, position
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // status, found_index, entry_count, spread
);

    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    ulst_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_cmd         (q_cmd)
    );

    ulst_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_cmd         (q_cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- hdl/ulst_checker.sv -----
// port-level checks for the unique list engine, bound to the top level
module ulst_checker
    import ulst_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [STAT_W-1:0]   o_status;
    logic [FIDX_W-1:0]   o_fidx;
    logic [CNT_W-1:0]    o_count;
    logic [SPREAD_W-1:0] o_spread;

    assign o_status = m_axis_tdata[STAT_W-1:0];
    assign o_fidx   = m_axis_tdata[STAT_W+FIDX_W-1:STAT_W];
    assign o_count  = m_axis_tdata[STAT_W+FIDX_W+CNT_W-1:STAT_W+FIDX_W];
    assign o_spread = m_axis_tdata[OUT_BITS-1:STAT_W+FIDX_W+CNT_W];

    // a stalled result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> o_count <= CNT_W'(DEPTH))
        else $error("entry count above list depth");

    // a nonzero index only comes with an ok status
    a_fidx_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (o_fidx != '0) |-> (o_status == ST_OK))
        else $error("found index with failing status");

    a_empty_spread: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (o_count == '0) |-> (o_spread == '0))
        else $error("nonzero spread on empty list");

    // an empty-list status can only leave the list empty
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (o_status == ST_EMPTY) |-> (o_count == '0))
        else $error("empty status with entries present");

endmodule

bind unique_array_list_engine_core ulst_checker u_ulst_checker (.*);
